@@ sv/evmm_pkg.sv @@
// ----------------------------------------------------------------------------
// evmm_pkg
// Types and constants for the encoder velocity and magnet monitor.
// ----------------------------------------------------------------------------
package evmm_pkg;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIN_THRESH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL = 1'b1;

   localparam int THRESH_W  = 15;
   localparam int MIN_INT_W = 10;
   localparam int CSR_W     = 15;

   localparam logic [THRESH_W-1:0]  THRESH_RESET  = 15'd100;
   localparam logic [MIN_INT_W-1:0] MIN_INT_RESET = 10'd10;

   // rpm scale factor and the quotient width it bounds (|rpm| <= 30000)
   localparam int              SCALE_W   = 16;
   localparam logic [SCALE_W-1:0] RPM_SCALE = 16'd60000;
   localparam int              QUOT_W    = 15;
   localparam int              VEL_W     = 16;
   localparam int              CNT_W     = $clog2(QUOT_W);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUOT_W - 1);

   // status byte bits
   localparam int STAT_DETECT = 5;
   localparam int STAT_CLOSE  = 4;
   localparam int STAT_FAR    = 3;

   // health flags, packed so that status_ready is the lowest bit
   typedef struct packed {
      logic fan_fault;
      logic hardware_fault;
      logic spinning;
      logic magnet_strong;
      logic magnet_weak;
      logic magnet_missing;
      logic status_ready;
   } health_type;

   localparam int RSP_W = VEL_W + 1 + $bits(health_type);

endpackage

@@ sv/encoder_velocity_magnet_monitor.sv @@
// ----------------------------------------------------------------------------
// encoder_velocity_magnet_monitor
// Rotary encoder velocity estimate and magnet health flags from sensor polls.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  req_    | in        | tdata: angle_raw, status_byte, now_ms; tuser: read_ok
//  rsp_    | out       | tdata: velocity_rpm, sample_taken, seven health flags
//  csr_    | in        | write enable, index, data; no read-back
//
//  A poll that updates the velocity goes from accept through a multiply step,
//  15 restoring-division steps on a shared subtract/compare unit and a finish
//  step, after which the output register presents the word. Other polls go
//  from accept straight to the finish step, then the word is presented.
//  req_tready is high only while the sequencer is idle; one poll at a time.
//  A result held in the output register does not block the next accept, but
//  the finish step waits while rsp_tvalid is stalled.
//  Synchronous active-high reset clears control state and the loaded registers.
// ----------------------------------------------------------------------------
module encoder_velocity_magnet_monitor #(
   parameter int TIME_WIDTH = 32,
   parameter int ANGLE_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   // angle_raw, status_byte, now_ms from bit 0 up, zero padded
   input  logic [((ANGLE_BITS+8+TIME_WIDTH+7)/8)*8-1:0] req_tdata,
   // read_ok
   input  logic                                        req_tuser,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // velocity_rpm, sample_taken, status_ready, magnet_missing, magnet_weak,
   // magnet_strong, spinning, hardware_fault, fan_fault from bit 0 up
   output logic [evmm_pkg::RSP_W-1:0]                  rsp_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   input  logic                                        csr_wen,
   input  logic [evmm_pkg::CSR_IDX_W-1:0]              csr_index,
   input  logic [evmm_pkg::CSR_W-1:0]                  csr_wdata
);
   import evmm_pkg::*;

   localparam int PROD_W = ANGLE_BITS + SCALE_W;
   localparam logic signed [ANGLE_BITS+1:0] HALF = (ANGLE_BITS+2)'(1) <<< (ANGLE_BITS-1);
   localparam logic signed [ANGLE_BITS+1:0] FULL = (ANGLE_BITS+2)'(1) <<< ANGLE_BITS;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [THRESH_W-1:0]        thr_ff, thr_in;
   logic [MIN_INT_W-1:0]       minint_ff, minint_in;
   logic [ANGLE_BITS-1:0]      last_angle_ff, last_angle_in;
   logic [TIME_WIDTH-1:0]      last_time_ff, last_time_in;
   logic signed [VEL_W-1:0]    vel_ff, vel_in;
   health_type                 flags_ff, flags_in;
   logic                       ok_ff, ok_in;
   logic                       taken_ff, taken_in;
   logic                       neg_ff, neg_in;
   logic [ANGLE_BITS-1:0]      mag_ff, mag_in;
   logic [2:0]                 stat_ff, stat_in;
   logic [TIME_WIDTH-1:0]      dt_ff, dt_in;
   logic [QUOT_W-1:0]          quot_ff, quot_in;
   logic [TIME_WIDTH-1:0]      rem_ff, rem_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]           rsp_data_ff, rsp_data_in;

   logic [ANGLE_BITS-1:0]       req_angle;
   logic [7:0]                  req_status;
   logic [TIME_WIDTH-1:0]       req_now;
   logic [TIME_WIDTH-1:0]       req_dt;
   logic [MIN_INT_W-1:0]        minint_eff;
   logic signed [ANGLE_BITS+1:0] raw_delta;
   logic signed [ANGLE_BITS+1:0] wrap_delta;
   logic signed [ANGLE_BITS+1:0] abs_delta;
   logic [PROD_W-1:0]           product;
   logic [TIME_WIDTH:0]         trial;
   logic                        trial_ge;
   logic signed [VEL_W-1:0]     quot_signed;
   logic signed [VEL_W-1:0]     vel_new;
   logic [VEL_W-1:0]            vel_abs;
   health_type                  flags_new;
   logic                        accept;

   assign req_angle  = req_tdata[ANGLE_BITS-1:0];
   assign req_status = req_tdata[ANGLE_BITS +: 8];
   assign req_now    = req_tdata[ANGLE_BITS+8 +: TIME_WIDTH];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // elapsed time and wrapped angle change against the last sample
   assign req_dt     = req_now - last_time_ff;
   assign minint_eff = (minint_ff == '0) ? MIN_INT_W'(1) : minint_ff;
   assign raw_delta  = $signed({2'b00, req_angle}) - $signed({2'b00, last_angle_ff});

   always_comb begin
      wrap_delta = raw_delta;
      if (raw_delta > HALF) begin
         wrap_delta = raw_delta - FULL;
      end else if (raw_delta < -HALF) begin
         wrap_delta = raw_delta + FULL;
      end
      abs_delta = (wrap_delta < 0) ? -wrap_delta : wrap_delta;
   end

   // multiplier used in S_MUL, restoring subtract/compare unit used in S_DIV
   assign product  = PROD_W'(mag_ff) * PROD_W'(RPM_SCALE);
   assign trial    = {rem_ff, quot_ff[QUOT_W-1]};
   assign trial_ge = (trial >= {1'b0, dt_ff});

   assign quot_signed = $signed({1'b0, quot_ff});
   assign vel_new     = taken_ff ? (neg_ff ? -quot_signed : quot_signed) : vel_ff;
   assign vel_abs     = (vel_new < 0) ? VEL_W'(-vel_new) : VEL_W'(vel_new);

   always_comb begin
      flags_new = flags_ff;
      if (!ok_ff) begin
         flags_new.hardware_fault = 1'b1;
         flags_new.fan_fault      = 1'b1;
      end else begin
         flags_new.status_ready   = 1'b1;
         flags_new.magnet_missing = !stat_ff[2];
         flags_new.magnet_weak    = stat_ff[2] && stat_ff[0];
         flags_new.magnet_strong  = stat_ff[2] && !stat_ff[0] && stat_ff[1];
         flags_new.spinning       = vel_abs > {1'b0, thr_ff};
         flags_new.hardware_fault = 1'b0;
         flags_new.fan_fault      = flags_new.magnet_missing || flags_new.magnet_weak
                                    || flags_new.magnet_strong;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      thr_in        = thr_ff;
      minint_in     = minint_ff;
      last_angle_in = last_angle_ff;
      last_time_in  = last_time_ff;
      vel_in        = vel_ff;
      flags_in      = flags_ff;
      ok_in         = ok_ff;
      taken_in      = taken_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      stat_in       = stat_ff;
      dt_in         = dt_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      if (csr_wen) begin
         case (csr_index)
            CSR_SPIN_THRESH:  thr_in    = csr_wdata[THRESH_W-1:0];
            CSR_MIN_INTERVAL: minint_in = csr_wdata[MIN_INT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ok_in    = req_tuser;
               taken_in = req_tuser && (req_dt >= TIME_WIDTH'(minint_eff));
               neg_in   = wrap_delta < 0;
               mag_in   = abs_delta[ANGLE_BITS-1:0];
               stat_in  = {req_status[STAT_DETECT], req_status[STAT_CLOSE],
                           req_status[STAT_FAR]};
               dt_in    = req_dt;
               if (req_tuser && (req_dt >= TIME_WIDTH'(minint_eff))) begin
                  last_angle_in = req_angle;
                  last_time_in  = req_now;
                  state_in      = S_MUL;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_MUL: begin
            // dividing by dt*2^ANGLE_BITS equals dividing the shifted product by dt
            quot_in  = product[ANGLE_BITS +: QUOT_W];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            quot_in = {quot_ff[QUOT_W-2:0], trial_ge};
            rem_in  = trial_ge ? TIME_WIDTH'(trial - {1'b0, dt_ff}) : trial[TIME_WIDTH-1:0];
            if (cnt_ff == DIV_LAST) begin
               state_in = S_FIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               vel_in       = vel_new;
               flags_in     = flags_new;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {flags_new, taken_ff, vel_new};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         thr_ff        <= THRESH_RESET;
         minint_ff     <= MIN_INT_RESET;
         last_angle_ff <= '0;
         last_time_ff  <= '0;
         vel_ff        <= '0;
         flags_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         thr_ff        <= thr_in;
         minint_ff     <= minint_in;
         last_angle_ff <= last_angle_in;
         last_time_ff  <= last_time_in;
         vel_ff        <= vel_in;
         flags_ff      <= flags_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff       <= ok_in;
      taken_ff    <= taken_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      stat_ff     <= stat_in;
      dt_ff       <= dt_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   // an accepted word leaves the sequencer busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("req_tready high right after accept");

   // a hardware fault always raises the fan fault in the same word
   a_hw_implies_fan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[VEL_W+1+5] || rsp_tdata[VEL_W+1+6]))
      else $error("hardware fault without fan fault");

   // magnet decode is a priority encode
   a_magnet_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[VEL_W+4:VEL_W+2]))
      else $error("more than one magnet flag set");

   // a new sample is never taken on a failed read
   a_taken_no_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[VEL_W]) |-> !rsp_tdata[VEL_W+1+5])
      else $error("sample taken with hardware fault");

endmodule

@@ test/evmm_checker.sv @@
// ----------------------------------------------------------------------------
// evmm_checker
// Watches the poll, result and csr channels of the velocity and magnet
// monitor, keeps its own model of the velocity estimate and health flags, and
// compares every result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module evmm_checker #(
   parameter int REQ_W = 56
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [REQ_W-1:0]               req_tdata,
   input  logic                           req_tuser,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [evmm_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_wen,
   input  logic [evmm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [evmm_pkg::CSR_W-1:0]     csr_wdata,
   output int                             error_count,
   output int                             pending_count
);
   import evmm_pkg::*;

   // same layout as rsp_tdata, velocity in the lowest bits
   typedef struct packed {
      health_type         flags;
      logic               taken;
      logic signed [15:0] velocity;
   } rsp_word_type;

   rsp_word_type rsp_expected[$];

   logic [THRESH_W-1:0]  spin_thresh;
   logic [MIN_INT_W-1:0] min_interval;
   logic [11:0]          prev_angle;
   logic [31:0]          prev_time;
   logic signed [15:0]   velocity;
   health_type           flags;

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   task automatic check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      end
   endtask

   task automatic predict_poll(input logic [11:0] ang, input logic [7:0] stat,
                               input logic [31:0] now, input logic ok);
      rsp_word_type want;
      logic [31:0]  dt;
      logic [31:0]  least_dt;
      int           delta;
      int           mag;
      longint       num;
      longint       den;
      want.taken = 1'b0;
      if (!ok) begin
         // bus error: only the two fault flags move
         flags.hardware_fault = 1'b1;
         flags.fan_fault      = 1'b1;
      end else begin
         dt       = now - prev_time;
         least_dt = (min_interval == '0) ? 32'd1 : {22'd0, min_interval};
         if (dt >= least_dt) begin
            delta = int'(ang) - int'(prev_angle);
            if (delta > 2048) delta -= 4096;
            if (delta < -2048) delta += 4096;
            num        = longint'(delta) * 60000;
            den        = longint'({32'd0, dt}) << 12;
            velocity   = 16'(num / den);
            prev_angle = ang;
            prev_time  = now;
            want.taken = 1'b1;
         end
         flags              = '0;
         flags.status_ready = 1'b1;
         if (!stat[STAT_DETECT])  flags.magnet_missing = 1'b1;
         else if (stat[STAT_FAR]) flags.magnet_weak    = 1'b1;
         else if (stat[STAT_CLOSE]) flags.magnet_strong = 1'b1;
         mag = int'(velocity);
         if (mag < 0) mag = -mag;
         flags.spinning  = (mag > int'({17'd0, spin_thresh}));
         flags.fan_fault = flags.magnet_missing | flags.magnet_weak | flags.magnet_strong;
      end
      want.velocity = velocity;
      want.flags    = flags;
      rsp_expected.push_back(want);
   endtask

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         spin_thresh  = THRESH_RESET;
         min_interval = MIN_INT_RESET;
         prev_angle   = '0;
         prev_time    = '0;
         velocity     = '0;
         flags        = '0;
         rsp_expected.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'(rsp_tdata);
            if (rsp_expected.size() == 0) begin
               error_count++;
               $display("%0t: result word with nothing pending, expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               want = rsp_expected.pop_front();
               check_field("velocity_rpm", int'($signed(want.velocity)),
                           int'($signed(got.velocity)));
               check_field("sample_taken", want.taken, got.taken);
               check_field("status_ready", want.flags.status_ready, got.flags.status_ready);
               check_field("magnet_missing", want.flags.magnet_missing,
                           got.flags.magnet_missing);
               check_field("magnet_weak", want.flags.magnet_weak, got.flags.magnet_weak);
               check_field("magnet_strong", want.flags.magnet_strong,
                           got.flags.magnet_strong);
               check_field("spinning", want.flags.spinning, got.flags.spinning);
               check_field("hardware_fault", want.flags.hardware_fault,
                           got.flags.hardware_fault);
               check_field("fan_fault", want.flags.fan_fault, got.flags.fan_fault);
            end
         end
         if (csr_wen) begin
            if (csr_index == CSR_SPIN_THRESH) spin_thresh = csr_wdata[THRESH_W-1:0];
            else if (csr_index == CSR_MIN_INTERVAL) min_interval = csr_wdata[MIN_INT_W-1:0];
         end
         if (req_tvalid && req_tready)
            predict_poll(req_tdata[11:0], req_tdata[19:12], req_tdata[51:20], req_tuser);
      end
      pending_count = rsp_expected.size();
   end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives sensor polls and csr writes into the encoder velocity and magnet
// monitor: a directed run over angle wrap, time wrap, interval and threshold
// edges, then random phases under several register settings, with random
// gaps and stalls on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb;
   import evmm_pkg::*;

   localparam int REQ_W = ((12 + 8 + 32 + 7) / 8) * 8;
   localparam int LIMIT = 300000;

   logic                 clock;
   logic                 reset;
   logic [REQ_W-1:0]     req_tdata;
   logic                 req_tuser;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic                 csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   int errors;
   int pending;
   int cycle_count = 0;
   int req_words   = 0;
   int rsp_words   = 0;

   // generator state for the random phases
   logic [31:0]          poll_time;
   logic [11:0]          poll_angle;
   logic [MIN_INT_W-1:0] cur_min;

   encoder_velocity_magnet_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   evmm_checker #(.REQ_W(REQ_W)) monitor_check (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (errors),
      .pending_count (pending)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_poll(input logic [11:0] ang, input logic [7:0] stat,
                            input logic [31:0] now, input logic ok);
      int gap;
      // every fifth stretch of 50 words goes back to back
      gap = ((req_words / 50) % 5 == 0) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-52){1'b0}}, now, stat, ang};
      req_tuser  <= ok;
      do @(posedge clock); while (!req_tready);
      req_words++;
   endtask

   // drop valid, let every pending result drain and the sequencer go idle
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_MIN_INTERVAL) cur_min = val[MIN_INT_W-1:0];
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input int count);
      int          r;
      int          least;
      logic [7:0]  stat;
      logic        ok;
      least = (cur_min == '0) ? 1 : int'(cur_min);
      poll_time = $urandom;
      for (int i = 0; i < count; i++) begin
         ok = ($urandom_range(0, 99) >= 6);
         r = $urandom_range(0, 99);
         if (r < 5) poll_time = $urandom;
         else if (r < 25) poll_time = poll_time + $urandom_range(0, least);
         else poll_time = poll_time + $urandom_range(least, 3 * least + 2);
         if ($urandom_range(0, 99) < 20) poll_angle = 12'($urandom_range(0, 4095));
         else poll_angle = poll_angle + 12'($urandom_range(0, 1200) - 600);
         stat = 8'($urandom_range(0, 255));
         // mostly a detected magnet, so the far/close decode gets exercised
         if ($urandom_range(0, 99) >= 30) stat[STAT_DETECT] = ($urandom_range(0, 9) != 0);
         send_poll(poll_angle, stat, poll_time, ok);
      end
   endtask

   // result side: random stalls, calm stretches, one long hold-off
   initial begin
      int hold_len;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_words == 400) hold_len = 300;
         else if ((rsp_words / 70) % 4 == 0) hold_len = 0;
         else hold_len = $urandom_range(0, 4);
         if (hold_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_len) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_words++;
      end
   end

   initial begin
      logic [CSR_W-1:0] thr;
      logic [CSR_W-1:0] mn;
      reset      = 1'b1;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tvalid = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      cur_min    = MIN_INT_RESET;
      poll_angle = '0;
      poll_time  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: threshold 100, interval 10
      send_poll(12'd4095, 8'hFF, 32'hFFFF_FFFF, 1'b0);   // bus error before ready
      send_poll(12'd0,    8'h20, 32'd0,  1'b1);          // zero interval, no sample
      send_poll(12'd2048, 8'h00, 32'd1,  1'b1);          // too short, magnet missing
      send_poll(12'd2048, 8'h28, 32'd10, 1'b1);          // +half turn, weak
      send_poll(12'd0,    8'h30, 32'd20, 1'b1);          // -half turn, strong
      send_poll(12'd2049, 8'h38, 32'd30, 1'b1);          // wraps to -2047, far wins
      send_poll(12'd2049, 8'hDF, 32'd35, 1'b0);          // bus error keeps flags
      send_poll(12'd0,    8'h27, 32'd40, 1'b1);
      send_poll(12'd100,  8'h20, 32'hFFFF_FFFF, 1'b1);   // huge interval
      send_poll(12'd200,  8'h20, 32'd5,  1'b1);          // time wrap, too short
      send_poll(12'd300,  8'h20, 32'd9,  1'b1);          // time wrap, taken
      settle();

      write_reg(CSR_SPIN_THRESH, 15'd30000);
      write_reg(CSR_MIN_INTERVAL, 15'd0);                // acts as one
      send_poll(12'd300,  8'h20, 32'd9,  1'b1);
      send_poll(12'd2348, 8'h20, 32'd10, 1'b1);          // full scale positive
      send_poll(12'd300,  8'h20, 32'd11, 1'b1);          // full scale negative
      settle();

      write_reg(CSR_SPIN_THRESH, 15'd29999);
      write_reg(CSR_MIN_INTERVAL, 15'd1000);
      send_poll(12'd300,  8'h20, 32'd11,   1'b1);
      send_poll(12'd1000, 8'h20, 32'd1010, 1'b1);        // one short of interval
      send_poll(12'd1000, 8'h20, 32'd1011, 1'b1);        // exactly the interval
      settle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               thr = 15'd0;
               mn  = 15'd1;
            end
            1: begin
               thr = 15'd30000;
               mn  = 15'd1000;
            end
            2: begin
               thr = 15'd32767;
               mn  = 15'd0;
            end
            default: begin
               thr = 15'($urandom_range(0, 3000));
               mn  = 15'($urandom_range(1, 40));
            end
         endcase
         write_reg(CSR_SPIN_THRESH, thr);
         write_reg(CSR_MIN_INTERVAL, mn);
         run_phase(212);
         settle();
      end

      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
